/* sv/assert_macros.svh */
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CHP_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CHP_ASSERT(label, clk, rst_n, prop, msg)
`define CHP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* sv/chp_pkg.sv */
// Shared types and constants of the host command parser.
package chp_pkg;
    localparam int MAX_DATA_BYTES = 8;
    localparam int DEF_QUEUE_DEPTH = 4;
    localparam logic [7:0] CMD_START = 8'hF1;
    localparam logic [7:0] BIN_MODE  = 8'hE7;
    localparam logic [19:0] SPEED_CAP = 20'd1000000;
    localparam logic [7:0] DEF_BUS_COUNT = 8'd2;
    localparam logic [15:0] DEF_BUILD = 16'd0;

    localparam logic [2:0] K_REPLY   = 3'd0;
    localparam logic [2:0] K_TX      = 3'd1;
    localparam logic [2:0] K_ECHO    = 3'd2;
    localparam logic [2:0] K_CONSOLE = 3'd3;
    localparam logic [2:0] K_DIGOUT  = 3'd4;
    localparam logic [2:0] K_BUSSET  = 3'd5;
    localparam logic [2:0] K_BINARY  = 3'd6;

    localparam logic [0:0] REG_BUS_COUNT = 1'd0;
    localparam logic [0:0] REG_BUILD     = 1'd1;

    // Job handed from the front end to the back end.
    typedef enum logic [2:0] {
        J_SINGLE, J_TSYNC, J_DIGIN, J_ANALOG, J_PARAMS, J_INFO, J_KEEP, J_BUSCNT
    } t_job_kind;

    typedef struct packed {
        t_job_kind   job;
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [30:0] frame_id;
        logic        frame_extended;
        logic [1:0]  frame_bus;
        logic [3:0]  frame_length;
        logic [63:0] frame_data;
        logic        save_request;
        logic [31:0] arg;   // time word or bus settings, per job
        logic [15:0] arg2;  // build number, bus count or extended-analog flag
    } t_job;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [30:0] frame_id;
        logic        frame_extended;
        logic [1:0]  frame_bus;
        logic [3:0]  frame_length;
        logic [63:0] frame_data;
        logic        save_request;
        logic        last;
    } t_result;

    function automatic logic [19:0] clamp_speed(input logic [31:0] w);
        logic [19:0] s;
        s = w[19:0];
        return (s > SPEED_CAP) ? SPEED_CAP : s;
    endfunction
endpackage

/* sv/chp_front.sv */
// Front end: parses host bytes and issues one job per result-causing byte.
module chp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_rx_byte,
    input  logic [31:0]    i_time_us,
    input  logic [7:0]     i_bus_count,
    input  logic [15:0]    i_build_number,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output chp_pkg::t_job  o_job
);
    import chp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CMD, S_BUILD, S_TSYNC, S_DIGOUT, S_SETUP, S_SWMODE, S_SYSTYPE,
        S_ECHO, S_EXTBUS
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic [30:0] r_id, n_id;
    logic        r_ext, n_ext;
    logic [1:0]  r_bus, n_bus;
    logic [3:0]  r_len, n_len;
    logic [63:0] r_data, n_data;
    logic [31:0] r_word, n_word;
    logic        r_b0_en, n_b0_en, r_b0_lo, n_b0_lo, r_b1_en, n_b1_en, r_b1_lo, n_b1_lo;
    logic [19:0] r_b0_sp, n_b0_sp, r_b1_sp, n_b1_sp;
    logic        r_jv, n_jv;
    t_job        r_job, n_job;
    logic        w_take;
    logic [31:0] w_word;
    logic [2:0]  w_slot;
    logic [7:0]  b;

    assign o_ready     = !r_jv || i_job_ready;
    assign w_take      = i_valid && o_ready;
    assign o_job_valid = r_jv;
    assign o_job       = r_job;
    assign b           = i_rx_byte;
    // Data bytes start at step six, so the byte slot is the step minus six, modulo eight.
    assign w_slot      = r_step[2:0] + 3'd2;

    always_comb begin
        n_state = r_state; n_step = r_step; n_id = r_id; n_ext = r_ext; n_bus = r_bus;
        n_len = r_len; n_data = r_data; n_word = r_word;
        n_b0_en = r_b0_en; n_b0_lo = r_b0_lo; n_b0_sp = r_b0_sp;
        n_b1_en = r_b1_en; n_b1_lo = r_b1_lo; n_b1_sp = r_b1_sp;
        n_jv = r_jv && !i_job_ready;
        n_job = '0;
        n_job.job = J_SINGLE;
        w_word = '0;
        if (w_take) begin
            n_job.arg = i_time_us;
            case (r_state)
                S_IDLE: begin
                    if (b == CMD_START) begin
                        n_state = S_CMD;
                    end else if (b == BIN_MODE) begin
                        n_jv = 1'b1; n_job.kind = K_BINARY;
                    end else begin
                        n_jv = 1'b1; n_job.kind = K_CONSOLE; n_job.byte_value = b;
                    end
                end
                S_CMD: begin
                    n_step = '0;
                    case (b)
                        8'd0: n_state = S_BUILD;
                        8'd1: begin n_state = S_TSYNC; n_jv = 1'b1; n_job.job = J_TSYNC; end
                        8'd2: begin n_state = S_IDLE; n_jv = 1'b1; n_job.job = J_DIGIN; end
                        8'd3: begin n_state = S_IDLE; n_jv = 1'b1; n_job.job = J_ANALOG; end
                        8'd4: begin n_state = S_DIGOUT; n_step = r_step; end
                        8'd5: n_state = S_SETUP;
                        8'd6: begin
                            n_state = S_IDLE; n_jv = 1'b1; n_job.job = J_PARAMS;
                            n_job.arg = {r_b0_lo, r_b0_en, r_b0_sp, 10'd0};
                            n_job.arg2 = '0;
                            n_job.frame_data = {20'd0, r_b1_lo, r_b1_en, r_b1_sp,
                                                r_b0_lo, r_b0_en, r_b0_sp};
                        end
                        8'd7: begin
                            n_state = S_IDLE; n_jv = 1'b1; n_job.job = J_INFO;
                            n_job.arg2 = i_build_number;
                        end
                        8'd8: n_state = S_SWMODE;
                        8'd9: begin n_state = S_IDLE; n_jv = 1'b1; n_job.job = J_KEEP; end
                        8'd10: n_state = S_SYSTYPE;
                        8'd11: n_state = S_ECHO;
                        8'd12: begin
                            n_state = S_IDLE; n_jv = 1'b1; n_job.job = J_BUSCNT;
                            n_job.arg2 = {8'd0, i_bus_count};
                        end
                        8'd13: begin n_state = S_IDLE; n_jv = 1'b1; n_job.job = J_ANALOG;
                            n_job.arg2 = 16'd1; end
                        8'd14: n_state = S_EXTBUS;
                        default: n_step = r_step;
                    endcase
                end
                S_BUILD, S_ECHO: begin
                    n_step = r_step + 4'd1;
                    case (r_step)
                        4'd0: n_id = {23'd0, b};
                        4'd1: n_id[15:8] = b;
                        4'd2: n_id[23:16] = b;
                        4'd3: begin n_id[30:24] = b[6:0]; n_ext = b[7]; end
                        4'd4: n_bus = (r_state == S_ECHO) ? {1'b0, b[0]} : b[1:0];
                        4'd5: begin
                            n_len = (b[3:0] > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES)
                                                                  : b[3:0];
                            n_data = '0;
                        end
                        default: begin
                            if (5'(r_step) < 5'(r_len) + 5'd6) begin
                                n_data[8*w_slot+:8] = b;
                            end else begin
                                n_state = S_IDLE;
                                if (r_state == S_ECHO || r_bus <= 2'd1) begin
                                    n_jv = 1'b1;
                                    n_job.kind = (r_state == S_ECHO) ? K_ECHO : K_TX;
                                    n_job.frame_id = r_id; n_job.frame_extended = r_ext;
                                    n_job.frame_bus = r_bus; n_job.frame_length = r_len;
                                    n_job.frame_data = r_data;
                                end
                            end
                        end
                    endcase
                end
                S_DIGOUT: begin
                    n_state = S_IDLE; n_jv = 1'b1; n_job.kind = K_DIGOUT; n_job.byte_value = b;
                end
                S_SETUP: begin
                    n_step = r_step + 4'd1;
                    w_word = (r_step[1:0] == 2'd0) ? 32'd0 : r_word;
                    w_word[8*r_step[1:0]+:8] = b;
                    n_word = w_word;
                    if (r_step[1:0] == 2'd3) begin
                        n_jv = 1'b1; n_job.kind = K_BUSSET;
                        if (!r_step[2]) begin
                            if (w_word != 0) begin
                                if (w_word[31]) begin
                                    n_b0_en = w_word[30]; n_b0_lo = w_word[29];
                                end else n_b0_en = 1'b1;
                                n_b0_sp = clamp_speed(w_word);
                            end else n_b0_en = 1'b0;
                        end else begin
                            if (w_word != 0 && i_bus_count > 8'd1) begin
                                if (w_word[31]) begin
                                    n_b1_en = w_word[30]; n_b1_lo = w_word[29];
                                end else n_b1_en = 1'b1;
                                n_b1_sp = clamp_speed(w_word);
                            end else n_b1_en = 1'b0;
                            n_job.save_request = 1'b1;
                            n_state = S_IDLE;
                        end
                        n_job.byte_value = {6'd0, n_b1_en, n_b0_en};
                    end
                end
                S_EXTBUS: begin
                    if (r_step >= 4'd11) n_state = S_IDLE;
                    n_step = r_step + 4'd1;
                end
                S_TSYNC, S_SWMODE, S_SYSTYPE: begin
                    n_state = S_IDLE; n_step = r_step + 4'd1;
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_step <= '0; r_id <= '0; r_ext <= 1'b0; r_bus <= '0;
            r_len <= '0; r_data <= '0; r_word <= '0;
            r_b0_en <= 1'b0; r_b0_lo <= 1'b0; r_b0_sp <= '0;
            r_b1_en <= 1'b0; r_b1_lo <= 1'b0; r_b1_sp <= '0;
            r_jv <= 1'b0;
        end else begin
            r_state <= n_state; r_step <= n_step; r_id <= n_id; r_ext <= n_ext;
            r_bus <= n_bus; r_len <= n_len; r_data <= n_data; r_word <= n_word;
            r_b0_en <= n_b0_en; r_b0_lo <= n_b0_lo; r_b0_sp <= n_b0_sp;
            r_b1_en <= n_b1_en; r_b1_lo <= n_b1_lo; r_b1_sp <= n_b1_sp;
            r_jv <= n_jv;
        end
        if (w_take && n_jv) r_job <= n_job;
    end
endmodule

/* sv/chp_queue.sv */
// Short job queue between the front and back ends.
module chp_queue #(
    parameter int DEPTH = chp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  chp_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output chp_pkg::t_job o_job
);
    import chp_pkg::*;
    localparam int AW = $clog2(DEPTH);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            w_push, w_pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_job;
    end
endmodule

/* sv/chp_back.sv */
// Back end: expands each job into its result transfers.
module chp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  chp_pkg::t_job    i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output chp_pkg::t_result o_res
);
    import chp_pkg::*;

    logic [4:0]  r_idx;
    logic [4:0]  w_count;
    logic [7:0]  w_byte;
    logic        w_last, w_adv;
    t_result     r_res;
    logic        r_ov;
    logic [59:0] p;

    assign p = i_job.frame_data[59:0];

    always_comb begin
        w_count = 5'd1;
        w_byte  = 8'd0;
        case (i_job.job)
            J_SINGLE: w_byte = i_job.byte_value;
            J_TSYNC: begin
                w_count = 5'd6;
                case (r_idx)
                    5'd0: w_byte = CMD_START;
                    5'd1: w_byte = 8'd1;
                    5'd2: w_byte = i_job.arg[7:0];
                    5'd3: w_byte = i_job.arg[15:8];
                    5'd4: w_byte = i_job.arg[23:16];
                    5'd5: w_byte = i_job.arg[31:24];
                    default: w_byte = 8'd0;
                endcase
            end
            J_DIGIN: begin
                w_count = 5'd4;
                w_byte = (r_idx == 5'd0) ? CMD_START : (r_idx == 5'd1) ? 8'd2 : 8'd0;
            end
            J_ANALOG: begin
                w_count = 5'd17;
                w_byte = (r_idx == 5'd0) ? CMD_START :
                         (r_idx == 5'd1) ? (i_job.arg2[0] ? 8'd13 : 8'd3) : 8'd0;
            end
            J_PARAMS: begin
                w_count = 5'd12;
                case (r_idx)
                    5'd0: w_byte = CMD_START;
                    5'd1: w_byte = 8'd6;
                    5'd2: w_byte = {3'd0, p[21], 3'd0, p[20]};
                    5'd3: w_byte = p[7:0];
                    5'd4: w_byte = p[15:8];
                    5'd5: w_byte = {4'd0, p[19:16]};
                    5'd7: w_byte = {3'd0, p[43], 3'd0, p[42]};
                    5'd8: w_byte = p[29:22];
                    5'd9: w_byte = p[37:30];
                    5'd10: w_byte = {4'd0, p[41:38]};
                    default: w_byte = 8'd0;
                endcase
            end
            J_INFO: begin
                w_count = 5'd8;
                case (r_idx)
                    5'd0: w_byte = CMD_START;
                    5'd1: w_byte = 8'd7;
                    5'd2: w_byte = i_job.arg2[7:0];
                    5'd3: w_byte = i_job.arg2[15:8];
                    5'd4: w_byte = 8'h20;
                    default: w_byte = 8'd0;
                endcase
            end
            J_KEEP: begin
                w_count = 5'd4;
                case (r_idx)
                    5'd0: w_byte = CMD_START;
                    5'd1: w_byte = 8'd9;
                    5'd2: w_byte = 8'hDE;
                    default: w_byte = 8'hAD;
                endcase
            end
            J_BUSCNT: begin
                w_count = 5'd3;
                w_byte = (r_idx == 5'd0) ? CMD_START : (r_idx == 5'd1) ? 8'd12
                                                                       : i_job.arg2[7:0];
            end
            default: w_byte = 8'd0;
        endcase
        w_last = (r_idx == w_count - 5'd1);
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign w_adv   = i_valid && (!r_ov || i_ready);
    assign o_ready = w_adv && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_idx <= '0;
        end else begin
            if (w_adv) begin
                r_ov  <= 1'b1;
                r_idx <= w_last ? 5'd0 : r_idx + 5'd1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
        if (w_adv) begin
            r_res.last <= w_last;
            r_res.byte_value <= w_byte;
            if (i_job.job == J_SINGLE) begin
                r_res.kind <= i_job.kind; r_res.frame_id <= i_job.frame_id;
                r_res.frame_extended <= i_job.frame_extended;
                r_res.frame_bus <= i_job.frame_bus;
                r_res.frame_length <= i_job.frame_length;
                r_res.frame_data <= i_job.frame_data;
                r_res.save_request <= i_job.save_request;
            end else begin
                r_res.kind <= K_REPLY; r_res.frame_id <= '0; r_res.frame_extended <= 1'b0;
                r_res.frame_bus <= '0; r_res.frame_length <= '0; r_res.frame_data <= '0;
                r_res.save_request <= 1'b0;
            end
        end
    end
endmodule

/* sv/can_host_command_parser_core.sv */
// Top level of the host command parser: config registers, front, queue, back.
// Input stream: one host byte per transfer, tdata = {time_us, rx_byte}.
// Output stream: one result per transfer; tdata packs kind, byte_value,
// frame_id, frame_extended, frame_bus, frame_length, frame_data, save_request;
// tlast marks the final result caused by one input byte.
// A result passes through the front-end job register, the job queue and the
// back-end result register. The front end takes one byte per cycle unless its
// job is held, and issues at most one job per byte; the back end emits one
// result per cycle unless stalled, so a reply holds the back end until all
// its bytes (up to seventeen) are sent. One byte per cycle is sustained while
// replies are short; the four-job queue takes long ones, and when full tready falls.
// A stalled output holds its result; the queue then fills and backs up the input.
// Reset (synchronous, active low) returns parsing to idle, clears bus settings,
// empties the queue and restores bus_count to 2 and build_number to 0.
// Configuration writes go straight into the registers.
module can_host_command_parser_core #(
    parameter int QUEUE_DEPTH = chp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // rx_byte[7:0], time_us[39:8]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,   // kind, byte_value, frame_id, frame_extended,
                                         // frame_bus, frame_length, frame_data,
                                         // save_request, zero fill
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    import chp_pkg::*;
    `include "assert_macros.svh"

    logic [7:0]  r_bus_count;
    logic [15:0] r_build;
    logic        w_fv, w_fr, w_qv, w_qr;
    t_job        w_fj, w_qj;
    t_result     w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_count <= DEF_BUS_COUNT; r_build <= DEF_BUILD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BUS_COUNT: r_bus_count <= i_cfg_data[7:0];
                REG_BUILD:     r_build <= i_cfg_data;
                default: ;
            endcase
        end
    end

    chp_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_rx_byte(s_axis_tdata[7:0]), .i_time_us(s_axis_tdata[39:8]),
        .i_bus_count(r_bus_count), .i_build_number(r_build),
        .o_job_valid(w_fv), .i_job_ready(w_fr), .o_job(w_fj)
    );

    chp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_job(w_fj),
        .o_valid(w_qv), .i_ready(w_qr), .o_job(w_qj)
    );

    chp_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_job(w_qj),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.save_request, w_res.frame_data, w_res.frame_length,
                           w_res.frame_bus, w_res.frame_extended, w_res.frame_id,
                           w_res.byte_value, w_res.kind};
    assign m_axis_tlast = w_res.last;

    `CHP_ASSERT(a_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "result changed while stalled")
    `CHP_ASSERT(a_save_kind, i_clk, i_rst_n,
        m_axis_tvalid && w_res.save_request |-> w_res.kind == K_BUSSET,
        "save request on wrong kind")
    `CHP_ASSERT(a_len, i_clk, i_rst_n,
        m_axis_tvalid |-> w_res.frame_length <= 4'(MAX_DATA_BYTES),
        "frame length above limit")
endmodule

/* tb/can_host_command_parser_core_tb.sv */
// Self-checking testbench of the host command parser core.
`timescale 1ns / 1ps

module can_host_command_parser_core_tb;
    import chp_pkg::*;

    typedef enum logic [3:0] {
        PS_IDLE, PS_CMD, PS_BUILD, PS_TSYNC, PS_DIGOUT, PS_SETUP, PS_SWMODE,
        PS_SYSTYPE, PS_ECHO, PS_EXTBUS
    } t_parse;

    localparam logic [7:0] C_BUILD = 8'd0, C_TSYNC = 8'd1, C_DIGIN = 8'd2,
        C_ANALOG = 8'd3, C_DIGOUT = 8'd4, C_SETUP = 8'd5, C_PARAMS = 8'd6,
        C_INFO = 8'd7, C_SWMODE = 8'd8, C_KEEP = 8'd9, C_SYSTYPE = 8'd10,
        C_ECHO = 8'd11, C_BUSCNT = 8'd12, C_EXTQ = 8'd13, C_EXTSET = 8'd14;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_we;
    logic [0:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;

    can_host_command_parser_core dut (.*);

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state
    logic [7:0]  cfg_bus_count;
    logic [15:0] cfg_build;
    t_parse      ps;
    logic [3:0]  step;
    logic [30:0] a_id;
    logic        a_ext;
    logic [1:0]  a_bus;
    logic [3:0]  a_len;
    logic [63:0] a_data;
    logic [31:0] word_acc;
    logic        b0_en, b0_lo, b1_en, b1_lo;
    logic [19:0] b0_speed, b1_speed;

    t_result expected_results[$];
    t_result pending[$];
    int      mismatches = 0;
    bit      idle_enable = 1'b1;
    int      hold_cycles = 0;

    function automatic logic [19:0] speed_of(logic [31:0] w);
        return (w[19:0] > 20'd1000000) ? 20'd1000000 : w[19:0];
    endfunction

    function automatic void emit(logic [2:0] k, logic [7:0] v, bit frame, bit save);
        t_result r;
        r = '0;
        r.kind = k;
        r.byte_value = v;
        if (frame) begin
            r.frame_id = a_id;
            r.frame_extended = a_ext;
            r.frame_bus = a_bus;
            r.frame_length = a_len;
            r.frame_data = a_data;
        end
        r.save_request = save;
        pending.push_back(r);
    endfunction

    function automatic void emit_reply(logic [7:0] v);
        emit(K_REPLY, v, 1'b0, 1'b0);
    endfunction

    // Returns 1 when the trailing byte of a frame arrives.
    function automatic bit frame_step(logic [7:0] b, logic [1:0] mask);
        if (step <= 2) begin
            if (step == 0) a_id = '0;
            a_id = a_id | (31'(b) << (8 * step));
        end else if (step == 3) begin
            a_id[30:24] = b[6:0];
            a_ext = b[7];
        end else if (step == 4) begin
            a_bus = b[1:0] & mask;
        end else if (step == 5) begin
            a_len = (b[3:0] > 4'd8) ? 4'd8 : b[3:0];
            a_data = '0;
        end else if (5'(step) < 5'(a_len) + 5'd6) begin
            a_data[8 * ((step - 6) & 7) +: 8] = b;
        end else begin
            ps = PS_IDLE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void run_command(logic [7:0] b, logic [31:0] t);
        case (b)
            C_BUILD: begin ps = PS_BUILD; step = '0; end
            C_TSYNC: begin
                ps = PS_TSYNC; step = '0;
                emit_reply(CMD_START); emit_reply(8'd1);
                for (int i = 0; i < 4; i++) emit_reply(t[8 * i +: 8]);
            end
            C_DIGIN: begin
                emit_reply(CMD_START); emit_reply(8'd2);
                repeat (2) emit_reply(8'd0);
                ps = PS_IDLE;
            end
            C_ANALOG: begin
                emit_reply(CMD_START); emit_reply(8'd3);
                repeat (15) emit_reply(8'd0);
                ps = PS_IDLE;
            end
            C_DIGOUT: ps = PS_DIGOUT;
            C_SETUP: begin ps = PS_SETUP; step = '0; end
            C_PARAMS: begin
                emit_reply(CMD_START); emit_reply(8'd6);
                emit_reply({3'b0, b0_lo, 3'b0, b0_en});
                emit_reply(b0_speed[7:0]); emit_reply(b0_speed[15:8]);
                emit_reply({4'b0, b0_speed[19:16]}); emit_reply(8'd0);
                emit_reply({3'b0, b1_lo, 3'b0, b1_en});
                emit_reply(b1_speed[7:0]); emit_reply(b1_speed[15:8]);
                emit_reply({4'b0, b1_speed[19:16]}); emit_reply(8'd0);
                ps = PS_IDLE;
            end
            C_INFO: begin
                emit_reply(CMD_START); emit_reply(8'd7);
                emit_reply(cfg_build[7:0]); emit_reply(cfg_build[15:8]);
                emit_reply(8'h20);
                repeat (3) emit_reply(8'd0);
                ps = PS_IDLE;
            end
            C_SWMODE: begin ps = PS_SWMODE; step = '0; end
            C_KEEP: begin
                emit_reply(CMD_START); emit_reply(8'd9);
                emit_reply(8'hDE); emit_reply(8'hAD);
                ps = PS_IDLE;
            end
            C_SYSTYPE: begin ps = PS_SYSTYPE; step = '0; end
            C_ECHO: begin ps = PS_ECHO; step = '0; end
            C_BUSCNT: begin
                emit_reply(CMD_START); emit_reply(8'd12); emit_reply(cfg_bus_count);
                ps = PS_IDLE;
            end
            C_EXTQ: begin
                emit_reply(CMD_START); emit_reply(8'd13);
                repeat (15) emit_reply(8'd0);
                step = '0; ps = PS_IDLE;
            end
            C_EXTSET: begin ps = PS_EXTBUS; step = '0; end
            default: ;
        endcase
    endfunction

    function automatic void setup_step(logic [7:0] b);
        logic [2:0]  s;
        logic [31:0] w;
        s = step[2:0];
        if (s[1:0] == 2'd0) word_acc = '0;
        word_acc[8 * s[1:0] +: 8] = b;
        if (s[1:0] != 2'd3) return;
        w = word_acc;
        if (s == 3'd3) begin
            if (w != 0) begin
                if (w[31]) begin b0_en = w[30]; b0_lo = w[29]; end
                else b0_en = 1'b1;
                b0_speed = speed_of(w);
            end else b0_en = 1'b0;
            emit(K_BUSSET, {6'b0, b1_en, b0_en}, 1'b0, 1'b0);
        end else begin
            if (w != 0 && cfg_bus_count > 1) begin
                if (w[31]) begin b1_en = w[30]; b1_lo = w[29]; end
                else b1_en = 1'b1;
                b1_speed = speed_of(w);
            end else b1_en = 1'b0;
            emit(K_BUSSET, {6'b0, b1_en, b0_en}, 1'b0, 1'b1);
            ps = PS_IDLE;
        end
    endfunction

    // Works out the results of one accepted host byte and queues them.
    function automatic void predict_byte(logic [7:0] b, logic [31:0] t);
        pending.delete();
        case (ps)
            PS_IDLE:
                if (b == CMD_START) ps = PS_CMD;
                else if (b == BIN_MODE) emit(K_BINARY, 8'd0, 1'b0, 1'b0);
                else emit(K_CONSOLE, b, 1'b0, 1'b0);
            PS_CMD: run_command(b, t);
            PS_BUILD: begin
                if (frame_step(b, 2'b11) && a_bus <= 1) emit(K_TX, 8'd0, 1'b1, 1'b0);
                step = step + 4'd1;
            end
            PS_ECHO: begin
                if (frame_step(b, 2'b01)) emit(K_ECHO, 8'd0, 1'b1, 1'b0);
                step = step + 4'd1;
            end
            PS_DIGOUT: begin
                emit(K_DIGOUT, b, 1'b0, 1'b0);
                ps = PS_IDLE;
            end
            PS_SETUP: begin
                setup_step(b);
                step = step + 4'd1;
            end
            PS_EXTBUS: begin
                if (step >= 11) ps = PS_IDLE;
                step = step + 4'd1;
            end
            default: ps = PS_IDLE;
        endcase
        if (pending.size() > 0) pending[pending.size() - 1].last = 1'b1;
        foreach (pending[i]) expected_results.push_back(pending[i]);
    endfunction

    // Leaves tvalid high after the transfer; the next call drives it anew and a drain wait drops it.
    task automatic send_byte(logic [7:0] b);
        logic [31:0] t;
        t = $urandom();
        while (idle_enable && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {t, b};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_byte(b, t);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_BUS_COUNT) cfg_bus_count = v[7:0];
        else cfg_build = v;
        @(posedge i_clk);
    endtask

    task automatic send_word(logic [31:0] w);
        for (int i = 0; i < 4; i++) send_byte(w[8 * i +: 8]);
    endtask

    task automatic send_frame(logic [7:0] cmd, logic [31:0] id, logic [7:0] bus,
                              logic [7:0] len_byte);
        int n;
        send_byte(CMD_START);
        send_byte(cmd);
        send_word(id);
        send_byte(bus);
        send_byte(len_byte);
        n = (len_byte[3:0] > 8) ? 8 : len_byte[3:0];
        for (int i = 0; i < n; i++) send_byte(8'($urandom()));
        send_byte(8'($urandom()));
    endtask

    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(BIN_MODE);
        send_frame(C_BUILD, 32'hFFFF_FFFF, 8'h01, 8'hFF);
        send_frame(C_BUILD, 32'h0000_0000, 8'h02, 8'h00);
        send_frame(C_ECHO, 32'h8123_4567, 8'hFF, 8'h03);
        for (int c = 1; c <= 15; c++) begin
            send_byte(CMD_START);
            send_byte(8'(c));
            case (8'(c))
                C_TSYNC, C_DIGOUT, C_SWMODE, C_SYSTYPE: send_byte(8'($urandom()));
                C_SETUP: begin
                    send_word(32'hFFFF_FFFF);
                    send_word(32'h000F_FFFF);
                end
                C_EXTSET: repeat (12) send_byte(8'($urandom()));
                default: ;
            endcase
        end
        send_byte(CMD_START);
        send_byte(8'hFF);
        send_byte(C_KEEP);
        send_byte(CMD_START);
        send_byte(C_SETUP);
        send_word(32'h0);
        send_word(32'h0);
        send_byte(CMD_START);
        send_byte(C_PARAMS);
    endtask

    task automatic random_item();
        logic [7:0] c;
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_byte(8'($urandom()));
            return;
        end
        c = 8'($urandom_range(15));
        if (pick < 14) c = 8'($urandom_range(16, 255));
        if (c == C_BUILD || c == C_ECHO) begin
            send_frame(c, $urandom(), 8'($urandom()), 8'($urandom()));
            return;
        end
        send_byte(CMD_START);
        send_byte(c);
        case (c)
            C_TSYNC, C_DIGOUT, C_SWMODE, C_SYSTYPE: send_byte(8'($urandom()));
            C_SETUP:
                for (int i = 0; i < 2; i++)
                    case ($urandom_range(3))
                        0: send_word(32'h0);
                        1: send_word({1'b1, 31'($urandom())});
                        2: send_word({12'h0, 20'($urandom())});
                        default: send_word($urandom());
                    endcase
            C_EXTSET: repeat (12) send_byte(8'($urandom()));
            default: ;
        endcase
    endtask

    task automatic test_random(int n_items, logic [7:0] bc, logic [15:0] bn);
        wait_drained();
        write_reg(REG_BUS_COUNT, 16'(bc));
        write_reg(REG_BUILD, bn);
        for (int i = 0; i < n_items; i++) random_item();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        idle_enable = 1'b0;
        repeat (6) begin
            send_byte(CMD_START);
            send_byte(C_ANALOG);
        end
        idle_enable = 1'b1;
        wait_drained();
        send_byte(CMD_START);
        send_byte(C_INFO);
    endtask

    // Result receiver with random stalls and one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_enable && $urandom_range(99) < 18);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_result got, exp;
            got = {m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[41:11],
                   m_axis_tdata[42], m_axis_tdata[44:43], m_axis_tdata[48:45],
                   m_axis_tdata[112:49], m_axis_tdata[113], m_axis_tlast};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %h", got);
            end else begin
                exp = expected_results.pop_front();
                if (got !== exp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp, got);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cfg_bus_count = DEF_BUS_COUNT;
        cfg_build = DEF_BUILD;
        ps = PS_IDLE;
        step = '0; a_id = '0; a_ext = 1'b0; a_bus = '0; a_len = '0; a_data = '0;
        word_acc = '0;
        b0_en = 1'b0; b0_lo = 1'b0; b0_speed = '0;
        b1_en = 1'b0; b1_lo = 1'b0; b1_speed = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(2, 8'd1, 16'hFFFF);
        idle_enable = 1'b0;
        test_random(2, 8'd255, 16'h0000);
        idle_enable = 1'b1;
        test_random(2, 8'd0, 16'h1234);
        test_random(2, 8'($urandom()), 16'($urandom()));
        wait_drained();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* can_host_command_parser_core.f */
+incdir+sv
sv/chp_pkg.sv
sv/chp_front.sv
sv/chp_queue.sv
sv/chp_back.sv
sv/can_host_command_parser_core.sv
tb/can_host_command_parser_core_tb.sv
